FILE: design/ramp_oscillator_variable_max_unit_macros.svh
// Assertion macros for the ramp oscillator block.
// Included by the top level; relies on clk and rst in the including scope.
`ifndef RAMP_OSCILLATOR_VARIABLE_MAX_UNIT_MACROS_SVH
`define RAMP_OSCILLATOR_VARIABLE_MAX_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ROVM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define ROVM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rovm_pkg.sv
// Shared types and constants for the ramp oscillator block.
// No dependencies; imported by ramp_oscillator_variable_max_unit.
`default_nettype none

package rovm_pkg;

  localparam int DATA_W    = 32;
  localparam int NORM_BITS = 16;
  localparam int NORM_W    = NORM_BITS + 1;
  localparam int SR_W      = 18;
  localparam int CFG_IDX_W = 1;
  localparam int CNT_W     = $clog2(DATA_W + 1);

  localparam logic [SR_W-1:0]   SR_RESET = SR_W'(48000);
  localparam logic [NORM_W-1:0] NORM_ONE = NORM_W'(1) << NORM_BITS;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_MODE  = 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] frequency;
    logic signed [DATA_W-1:0] ramp_max;
    logic signed [DATA_W-1:0] offset;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_value;
    logic [NORM_W-1:0]        norm_ramp;
  } out_item_t;

endpackage

`default_nettype wire

FILE: design/ramp_oscillator_variable_max_unit.sv
// Ramp oscillator: once a request is accepted the divider yields the phase step, then
// the wrap remainder (only on a wrap), then the ratio (only for a phase below a nonzero
// maximum), all on one shared shift-subtract divider that retires one bit a cycle.
// in_ready returns with out_valid; no new request is taken until that result is loaded.
// Synchronous active-high reset: sample rate 48000, latch mode off, phase and
// held offset zero, no result pending.
`default_nettype none
`include "ramp_oscillator_variable_max_unit_macros.svh"

module ramp_oscillator_variable_max_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire rovm_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output rovm_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [rovm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rovm_pkg::SR_W-1:0]       cfg_data
);
  import rovm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_STEP_DIV = 8'b0000_0010,
    S_ADD      = 8'b0000_0100,
    S_DECIDE   = 8'b0000_1000,
    S_MOD_DIV  = 8'b0001_0000,
    S_WRAP     = 8'b0010_0000,
    S_NORM_SET = 8'b0100_0000,
    S_NORM_DIV = 8'b1000_0000
  } state_t;

  state_t state;
  logic   finish;

  // Configuration
  logic [SR_W-1:0] sample_rate;
  logic            offset_latch_mode;

  // Oscillator state
  logic [DATA_W-2:0] ramp_phase;
  logic [DATA_W-1:0] held_offset;

  // Request operands
  logic              freq_neg;
  logic [DATA_W-2:0] max_c;
  logic [DATA_W-1:0] offset_in;
  logic              step_neg;
  logic [DATA_W+1:0] cur;
  logic              wrap_up;
  logic [NORM_W-1:0] norm_val;

  // Shared shift-subtract divider
  logic [DATA_W-1:0] div_rem;
  logic [DATA_W-1:0] div_quo;
  logic [DATA_W-1:0] div_den;
  logic [CNT_W-1:0]  div_cnt;
  logic [DATA_W:0]   div_shift;
  logic [DATA_W:0]   div_trial;
  logic              div_ge;
  logic [DATA_W-1:0] div_rem_next;
  logic [DATA_W-1:0] div_quo_next;
  logic              div_last;

  // Datapath helpers
  logic [DATA_W+1:0] step_ext;
  logic [DATA_W+1:0] cur_next;
  logic [DATA_W+1:0] cur_m1;
  logic [DATA_W+1:0] cur_neg;
  logic [DATA_W-1:0] offi;
  logic [DATA_W:0]   out_sum;
  logic [DATA_W-1:0] out_sat;
  logic [DATA_W-1:0] sr_den;
  logic [DATA_W-1:0] freq_mag;

  // Sequencer and datapath
  logic out_load;
  logic norm_done;

  state_t done_hold;
  logic   result_ready;

  assign in_ready = (state == S_IDLE) && !result_ready;

  // Divider step: shift in one dividend bit, trial subtract
  always_comb begin
    div_shift    = {div_rem, div_quo[DATA_W-1]};
    div_trial    = div_shift - {1'b0, div_den};
    div_ge       = ~div_trial[DATA_W];
    div_rem_next = div_ge ? div_trial[DATA_W-1:0] : div_shift[DATA_W-1:0];
    div_quo_next = {div_quo[DATA_W-2:0], div_ge};
    div_last     = (div_cnt == CNT_W'(1));
  end

  // Operand prep
  always_comb begin
    sr_den   = (sample_rate == '0) ? DATA_W'(1) : {{(DATA_W-SR_W){1'b0}}, sample_rate};
    freq_mag = in_data.frequency[DATA_W-1] ? (~in_data.frequency + DATA_W'(1))
                                           : in_data.frequency;
    step_ext = {2'b00, div_quo};
    cur_next = {3'b000, ramp_phase} + (step_neg ? (~step_ext + (DATA_W+2)'(1)) : step_ext);
    cur_m1   = cur - (DATA_W+2)'(1);
    cur_neg  = ~cur + (DATA_W+2)'(1);
  end

  // Output sum with saturation; only upward overflow is possible
  always_comb begin
    offi    = offset_latch_mode ? held_offset : offset_in;
    out_sum = {2'b00, ramp_phase} + {offi[DATA_W-1], offi};
    out_sat = (out_sum[DATA_W:DATA_W-1] == 2'b01) ? {1'b0, {(DATA_W-1){1'b1}}}
                                                  : out_sum[DATA_W-1:0];
    finish  = (state == S_NORM_SET || state == S_NORM_DIV);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate       <= SR_RESET;
      offset_latch_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_RATE: sample_rate       <= cfg_data;
        REG_LATCH_MODE:  offset_latch_mode <= cfg_data[0];
        default:         sample_rate       <= sample_rate;
      endcase
    end
  end

  always_comb begin
    norm_done = 1'b0;
    if (state == S_NORM_DIV && div_last) begin
      norm_done = 1'b1;
    end
  end

  // Hold the finished result until the output register is free
  always_ff @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (result_ready && (!out_valid || out_ready)) begin
      result_ready <= 1'b0;
    end else if (norm_done || (state == S_NORM_SET && done_hold == S_IDLE)) begin
      result_ready <= 1'b1;
    end
  end

  assign out_load = result_ready && (!out_valid || out_ready);

  always_comb begin
    done_hold = S_NORM_DIV;
    if (max_c == '0 || ramp_phase >= max_c) begin
      done_hold = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ramp_phase  <= '0;
      held_offset <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          // Take a request and start the step division
          if (in_valid && !result_ready) begin
            freq_neg  <= in_data.frequency[DATA_W-1];
            max_c     <= in_data.ramp_max[DATA_W-1] ? '0 : in_data.ramp_max[DATA_W-2:0];
            offset_in <= in_data.offset;
            div_rem   <= '0;
            div_quo   <= freq_mag;
            div_den   <= sr_den;
            div_cnt   <= CNT_W'(DATA_W);
            state     <= S_STEP_DIV;
          end
        end
        S_STEP_DIV: begin
          div_rem <= div_rem_next;
          div_quo <= div_quo_next;
          div_cnt <= div_cnt - CNT_W'(1);
          if (div_last) begin
            step_neg <= freq_neg && (div_quo_next != '0);
            state    <= S_ADD;
          end
        end
        S_ADD: begin
          cur   <= cur_next;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          // Clear, wrap up, wrap down, or keep the phase
          if (max_c == '0) begin
            ramp_phase <= '0;
            state      <= S_NORM_SET;
          end else if (!step_neg && (cur > {3'b000, max_c})) begin
            div_rem <= '0;
            div_quo <= cur_m1[DATA_W-1:0];
            div_den <= {1'b0, max_c};
            div_cnt <= CNT_W'(DATA_W);
            wrap_up <= 1'b1;
            state   <= S_MOD_DIV;
          end else if (step_neg && cur[DATA_W+1]) begin
            div_rem <= '0;
            div_quo <= cur_neg[DATA_W-1:0];
            div_den <= {1'b0, max_c};
            div_cnt <= CNT_W'(DATA_W);
            wrap_up <= 1'b0;
            state   <= S_MOD_DIV;
          end else begin
            ramp_phase <= cur[DATA_W-2:0];
            state      <= S_NORM_SET;
          end
        end
        S_MOD_DIV: begin
          div_rem <= div_rem_next;
          div_quo <= div_quo_next;
          div_cnt <= div_cnt - CNT_W'(1);
          if (div_last) begin
            state <= S_WRAP;
          end
        end
        S_WRAP: begin
          // Fold the remainder back into the ramp range; an upward wrap in latch mode also takes the offset
          if (wrap_up) begin
            ramp_phase <= div_rem[DATA_W-2:0] + (DATA_W-1)'(1);
            if (offset_latch_mode) begin
              held_offset <= offset_in[DATA_W-1] ? '0 : offset_in;
            end
          end else if (div_rem == '0) begin
            ramp_phase <= '0;
          end else begin
            ramp_phase <= max_c - div_rem[DATA_W-2:0];
          end
          state <= S_NORM_SET;
        end
        S_NORM_SET: begin
          // Ratio is zero for a zero maximum and saturates at or above it
          if (max_c == '0) begin
            norm_val <= '0;
            state    <= S_IDLE;
          end else if (ramp_phase >= max_c) begin
            norm_val <= NORM_ONE;
            state    <= S_IDLE;
          end else begin
            div_rem <= {1'b0, ramp_phase};
            div_quo <= '0;
            div_den <= {1'b0, max_c};
            div_cnt <= CNT_W'(NORM_BITS);
            state   <= S_NORM_DIV;
          end
        end
        S_NORM_DIV: begin
          div_rem <= div_rem_next;
          div_quo <= div_quo_next;
          div_cnt <= div_cnt - CNT_W'(1);
          if (div_last) begin
            norm_val <= {1'b0, div_quo_next[NORM_BITS-1:0]};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.out_value <= out_sat;
      out_data.norm_ramp <= norm_val;
    end
  end

  `ROVM_ASSERT_NEXT(a_accept_busy,
    in_valid && in_ready && !result_ready && !finish, !in_ready,
    "block still ready after taking a request")
  `ROVM_ASSERT_IMPL(a_div_rem_bound,
    state == S_STEP_DIV || state == S_MOD_DIV || state == S_NORM_DIV, div_rem < div_den,
    "divider remainder reached the divisor")
  `ROVM_ASSERT_IMPL(a_norm_bound,
    out_valid, !(out_data.norm_ramp[NORM_BITS] && (out_data.norm_ramp[NORM_BITS-1:0] != '0)),
    "normalized ramp above one")

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for ramp_oscillator_variable_max_unit.
// Drives requests and config writes, predicts each phase/ratio result in a
// small class; depends on rovm_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_top;
  import rovm_pkg::*;

  localparam longint SR0       = 48000;
  localparam int     RUN_ITEMS = 140;
  localparam int     LIMIT     = 2_000_000;
  localparam longint S32_MAX   = 64'sd2147483647;
  localparam longint S32_MIN   = -64'sd2147483648;

  // Ramp predictor: own copy of the registers and the phase state, plus the
  // results still owed by the block.
  class ramp_predictor;
    logic [SR_W-1:0] rate;
    bit              latch_mode;
    int              phase;
    int              held_offset;
    out_item_t       pending_results[$];
    int              errors;
    int unsigned     accepted;

    function new();
      rate        = SR_RESET;
      latch_mode  = 1'b0;
      phase       = 0;
      held_offset = 0;
      errors      = 0;
      accepted    = 0;
    endfunction

    function void configure(logic [SR_W-1:0] new_rate, bit new_mode);
      rate       = new_rate;
      latch_mode = new_mode;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Advance the phase for one request and queue the result it owes
    function void note_request(in_item_t req);
      longint          freq, lim, offin, eff, step, cur, rem, offi, sum;
      longint unsigned ucur, ulim, norm;
      out_item_t       res;
      freq  = $signed(req.frequency);
      lim   = $signed(req.ramp_max);
      offin = $signed(req.offset);
      eff   = (rate == '0) ? 64'sd1 : longint'(rate);
      step  = freq / eff;
      cur   = longint'(phase) + step;
      if (lim < 0) lim = 0;

      if (lim == 0) begin
        cur = 0;
      end else if (step >= 0) begin
        // upward wrap lands in (0, max]
        if (cur > lim) begin
          cur = ((cur - 1) % lim) + 1;
          if (latch_mode) held_offset = (offin < 0) ? 0 : int'(offin);
        end
      end else if (cur < 0) begin
        // downward wrap lands in [0, max)
        rem = cur % lim;
        if (rem < 0) rem += lim;
        cur = rem;
      end
      phase = int'(cur);

      offi = latch_mode ? longint'(held_offset) : offin;
      norm = 0;
      if (lim != 0) begin
        ucur = $unsigned(cur);
        ulim = $unsigned(lim);
        norm = (ucur << NORM_BITS) / ulim;
        if (norm > 64'd65536) norm = 64'd65536;
      end

      sum = cur + offi;
      if (sum > S32_MAX) sum = S32_MAX;
      if (sum < S32_MIN) sum = S32_MIN;
      res.out_value = sum[DATA_W-1:0];
      res.norm_ramp = norm[NORM_W-1:0];
      pending_results.push_back(res);
      accepted++;
    endfunction

    // Compare one delivered result with the oldest owed one
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: out_value %0d norm_ramp %0d",
               got.out_value, got.norm_ramp);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.out_value !== want.out_value) begin
        $error("out_value: expected %0d, got %0d", want.out_value, got.out_value);
        errors++;
      end
      if (got.norm_ramp !== want.norm_ramp) begin
        $error("norm_ramp: expected %0d, got %0d", want.norm_ramp, got.norm_ramp);
        errors++;
      end
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SR_W-1:0]      cfg_data  = '0;

  ramp_predictor sb = new();
  int unsigned   cycles = 0;
  int unsigned   run_max = 1000;
  bit            run_down = 1'b0;

  ramp_oscillator_variable_max_unit u_top (
    .clk,
    .rst,
    .in_valid,
    .in_ready,
    .in_data,
    .out_valid,
    .out_ready,
    .out_data,
    .cfg_we,
    .cfg_index,
    .cfg_data
  );

  always #6 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Check every result the receiver takes
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 30);
    return $urandom_range(60, 200);
  endfunction

  function automatic in_item_t req_of(longint f, longint m, longint o);
    in_item_t req;
    req.frequency = f[DATA_W-1:0];
    req.ramp_max  = m[DATA_W-1:0];
    req.offset    = o[DATA_W-1:0];
    return req;
  endfunction

  // Random request: mostly a running ramp with steps sized against its
  // maximum, the rest zero/negative maxima and plain noise
  function automatic in_item_t rand_request();
    in_item_t    req;
    longint      eff, goal, f;
    int unsigned pick;
    eff = (sb.rate == '0) ? 64'sd1 : longint'(sb.rate);
    req.frequency = $urandom();
    req.ramp_max  = $urandom();
    req.offset    = $urandom();
    if ($urandom_range(0, 19) == 0) begin
      run_max  = $urandom_range(1, 1 << $urandom_range(0, 20));
      run_down = ($urandom_range(0, 3) == 0);
    end
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      req.ramp_max = ($urandom_range(0, 1) == 1) ? '0 : (32'h8000_0000 | $urandom());
    end else if (pick >= 20) begin
      goal = longint'($urandom_range(0, run_max + run_max / 2));
      if (run_down ^ ($urandom_range(0, 4) == 0)) goal = -goal;
      f = goal * eff;
      if (goal < 0) f = f - longint'($urandom_range(0, 32'(eff - 1)));
      else          f = f + longint'($urandom_range(0, 32'(eff - 1)));
      if (f > S32_MAX) f = S32_MAX;
      if (f < S32_MIN) f = S32_MIN;
      req.frequency = f[DATA_W-1:0];
      // occasionally drop the maximum under the running phase
      req.ramp_max = ($urandom_range(0, 9) == 0) ? $urandom_range(1, run_max) : run_max;
    end
    case ($urandom_range(0, 9))
      0:       req.offset = 32'h7FFF_FFFF;
      1:       req.offset = 32'h8000_0000;
      default: ;
    endcase
    return req;
  endfunction

  // Offer one request after an optional gap; return at a falling edge
  task automatic send_req(input in_item_t req, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed result has arrived
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write both registers on consecutive cycles while the block is idle
  task automatic configure(input logic [SR_W-1:0] rate, input logic [SR_W-1:0] mode_word);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SAMPLE_RATE;
    cfg_data  <= rate;
    @(negedge clk);
    cfg_index <= REG_LATCH_MODE;
    cfg_data  <= mode_word;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.configure(rate, mode_word[0]);
  endtask

  // Receiver: random ready pattern, one long hold-off to back up the block
  initial begin : receiver
    int run;
    int gap;
    bit held_off;
    held_off = 1'b0;
    @(negedge clk);
    forever begin
      if (!held_off && sb.accepted >= 300) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (3000) @(negedge clk);
      end
      out_ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 20);
      repeat (run) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned rate_list[7];
    bit          mode_list[7];
    bit          quiet;
    rate_list = '{48000, 1, 192000, 0, 262143, 0, 96000};
    mode_list = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed requests at reset settings
    send_req(req_of(0, 0, 0), pick_gap());                          // zero maximum
    send_req(req_of(SR0 * 40000, S32_MAX, 0), pick_gap());          // build up phase
    send_req(req_of(-SR0, 100, 0), pick_gap());                     // phase above max
    send_req(req_of(SR0 * 7, 100, 0), pick_gap());                  // wrap from far above
    send_req(req_of(SR0 - 1, 100, 0), pick_gap());                  // step truncates to 0
    send_req(req_of(-(SR0 - 1), 100, 0), pick_gap());               // negative truncates to 0
    send_req(req_of(S32_MIN, 100, 0), pick_gap());                  // big downward wrap
    send_req(req_of(S32_MAX, 100, S32_MAX), pick_gap());            // wrap, saturate high
    send_req(req_of(SR0 * 3, S32_MIN, 0), pick_gap());              // negative maximum
    send_req(req_of(SR0 * 3, -1, S32_MIN), pick_gap());
    send_req(req_of(SR0 * 100, 1000, S32_MIN), pick_gap());
    send_req(req_of(SR0 * 900, 1000, -1), pick_gap());              // phase equals max
    send_req(req_of(SR0, 1000, 0), pick_gap());                     // wrap to 1
    send_req(req_of(-SR0 * 2, 1000, 0), pick_gap());                // wrap to max - 1
    send_req(req_of(-SR0 * 999, 1000, 0), pick_gap());              // land on 0
    send_req(req_of(-SR0, 1, 0), pick_gap());                       // unit maximum
    settle();

    rate_list[5] = $urandom_range(1, 192000);
    mode_list[5] = 1'($urandom_range(0, 1));
    for (int p = 0; p < 7; p++) begin
      configure(SR_W'(rate_list[p]), {(SR_W-1)'($urandom()), mode_list[p]});
      if (p == 0) begin
        // latch mode: offset taken only on an upward wrap, clamped at 0
        send_req(req_of(0, 0, 777), pick_gap());
        send_req(req_of(SR0 * 150, 100, 3000), pick_gap());
        send_req(req_of(SR0 * 10, 100, 9), pick_gap());
        send_req(req_of(SR0 * 95, 100, -4000), pick_gap());
        send_req(req_of(SR0 * 95, 100, S32_MAX), pick_gap());
        send_req(req_of(-SR0 * 500, 100, 5), pick_gap());
      end
      quiet = 1'b0;
      for (int n = 0; n < RUN_ITEMS; n++) begin
        if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
        send_req(rand_request(), quiet ? 0 : pick_gap());
      end
      settle();
    end

    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
